@@ design/tsp_pkg.sv @@
// Shared types and constants for the triangle surface property pipeline.
// Depends on nothing; every other design file refers to it by scoped names.
`default_nettype none
package tsp_pkg;

    // Bits of the wide root (area) and of the narrow roots (edge lengths).
    localparam int WROOT_BITS = 34;
    localparam int NROOT_BITS = 17;
    // Radicand widths: squared cross product sum, squared edge length.
    localparam int WRAD_BITS  = 2 * WROOT_BITS;
    localparam int NRAD_BITS  = 2 * NROOT_BITS;
    // Arithmetic stages ahead of the root pipeline, plus the output stage.
    localparam int FRONT_STAGES = 5;
    localparam int LATENCY      = FRONT_STAGES + WROOT_BITS + 1;
    // Reciprocal of three in 2^-17 units; exact for magnitudes below 2^17.
    localparam logic [15:0] RECIP3 = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    typedef struct packed {
        logic signed [15:0] vertex0_x;
        logic signed [15:0] vertex0_y;
        logic signed [15:0] vertex0_z;
        logic signed [15:0] vertex1_x;
        logic signed [15:0] vertex1_y;
        logic signed [15:0] vertex1_z;
        logic signed [15:0] vertex2_x;
        logic signed [15:0] vertex2_y;
        logic signed [15:0] vertex2_z;
        logic signed [15:0] normal_in_x;
        logic signed [15:0] normal_in_y;
        logic signed [15:0] normal_in_z;
    } t_in;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic signed [15:0] normal_out_x;
        logic signed [15:0] normal_out_y;
        logic signed [15:0] normal_out_z;
        logic        [32:0] tri_area;
        logic        [16:0] edge_long;
        logic        [16:0] edge_short;
    } t_out;

    // Fields that ride along the root pipeline unchanged.
    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } t_side;

    // One beat handed from the arithmetic front end to the root pipeline.
    typedef struct packed {
        logic                 valid;
        logic [WRAD_BITS-1:0] cross_sq;
        logic [NRAD_BITS-1:0] len1_sq;
        logic [NRAD_BITS-1:0] len2_sq;
        t_side                side;
    } t_rad;

endpackage
`default_nettype wire

@@ design/tsp_front.sv @@
// Arithmetic front end: edges, cross product, squared lengths and centroid.
// Five register stages; uses tsp_pkg types and constants.
`default_nettype none
module tsp_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  tsp_pkg::t_in   i_item,
    output tsp_pkg::t_rad  o_rad
);

    // Stage A: edges from vertex 0 and centroid sums split into sign and magnitude.
    logic               r_va;
    logic signed [16:0] r_e1 [3];
    logic signed [16:0] r_e2 [3];
    logic        [16:0] r_cmag [3];
    logic               r_cneg [3];
    logic signed [15:0] r_na [3];

    logic signed [15:0] w_v0 [3];
    logic signed [15:0] w_v1 [3];
    logic signed [15:0] w_v2 [3];
    logic signed [17:0] w_sum [3];

    always_comb begin
        w_v0[0] = i_item.vertex0_x; w_v0[1] = i_item.vertex0_y; w_v0[2] = i_item.vertex0_z;
        w_v1[0] = i_item.vertex1_x; w_v1[1] = i_item.vertex1_y; w_v1[2] = i_item.vertex1_z;
        w_v2[0] = i_item.vertex2_x; w_v2[1] = i_item.vertex2_y; w_v2[2] = i_item.vertex2_z;
        for (int j = 0; j < 3; j++) begin
            w_sum[j] = 18'(w_v0[j]) + 18'(w_v1[j]) + 18'(w_v2[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        for (int j = 0; j < 3; j++) begin
            r_e1[j]   <= 17'(w_v1[j]) - 17'(w_v0[j]);
            r_e2[j]   <= 17'(w_v2[j]) - 17'(w_v0[j]);
            r_cneg[j] <= w_sum[j][17];
            r_cmag[j] <= w_sum[j][17] ? 17'(-w_sum[j]) : w_sum[j][16:0];
        end
        r_na[0] <= i_item.normal_in_x;
        r_na[1] <= i_item.normal_in_y;
        r_na[2] <= i_item.normal_in_z;
    end

    // Stage B: the six cross product terms, edge squares and the divide-by-three multiply.
    logic               r_vb;
    logic signed [33:0] r_px [6];
    logic        [32:0] r_s1 [3];
    logic        [32:0] r_s2 [3];
    logic        [32:0] r_cm [3];
    logic               r_cnb [3];
    logic signed [15:0] r_nb [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_px[0] <= r_e1[1] * r_e2[2];
        r_px[1] <= r_e1[2] * r_e2[1];
        r_px[2] <= r_e1[2] * r_e2[0];
        r_px[3] <= r_e1[0] * r_e2[2];
        r_px[4] <= r_e1[0] * r_e2[1];
        r_px[5] <= r_e1[1] * r_e2[0];
        for (int j = 0; j < 3; j++) begin
            r_s1[j]  <= 33'(34'(r_e1[j] * r_e1[j]));
            r_s2[j]  <= 33'(34'(r_e2[j] * r_e2[j]));
            r_cm[j]  <= 33'(r_cmag[j]) * 33'(tsp_pkg::RECIP3);
            r_cnb[j] <= r_cneg[j];
            r_nb[j]  <= r_na[j];
        end
    end

    // Stage C: cross product components to magnitudes, length sums, centroid sign.
    logic               r_vc;
    logic        [32:0] r_cabs [3];
    logic [tsp_pkg::NRAD_BITS-1:0] r_q1c, r_q2c;
    logic signed [15:0] r_ctr_c [3];
    logic signed [15:0] r_nc [3];

    logic signed [34:0] w_c [3];
    logic        [15:0] w_quo [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_c[j]   = 35'(r_px[2*j]) - 35'(r_px[2*j+1]);
            w_quo[j] = r_cm[j][tsp_pkg::RECIP3_SHIFT +: 16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else begin
            r_vc <= r_vb;
        end
        for (int j = 0; j < 3; j++) begin
            r_cabs[j]  <= w_c[j][34] ? 33'(-w_c[j]) : w_c[j][32:0];
            r_ctr_c[j] <= r_cnb[j] ? -$signed(w_quo[j]) : $signed(w_quo[j]);
            r_nc[j]    <= r_nb[j];
        end
        r_q1c <= tsp_pkg::NRAD_BITS'(r_s1[0]) + tsp_pkg::NRAD_BITS'(r_s1[1])
               + tsp_pkg::NRAD_BITS'(r_s1[2]);
        r_q2c <= tsp_pkg::NRAD_BITS'(r_s2[0]) + tsp_pkg::NRAD_BITS'(r_s2[1])
               + tsp_pkg::NRAD_BITS'(r_s2[2]);
    end

    // Stage D: square each cross product magnitude.
    logic        r_vd;
    logic [65:0] r_csq [3];
    logic [tsp_pkg::NRAD_BITS-1:0] r_q1d, r_q2d;
    tsp_pkg::t_side r_side_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else begin
            r_vd <= r_vc;
        end
        for (int j = 0; j < 3; j++) begin
            r_csq[j] <= 66'(r_cabs[j]) * 66'(r_cabs[j]);
        end
        r_q1d <= r_q1c;
        r_q2d <= r_q2c;
        r_side_d.center_x <= r_ctr_c[0];
        r_side_d.center_y <= r_ctr_c[1];
        r_side_d.center_z <= r_ctr_c[2];
        r_side_d.normal_x <= r_nc[0];
        r_side_d.normal_y <= r_nc[1];
        r_side_d.normal_z <= r_nc[2];
    end

    // Stage E: squared cross product magnitude, exact.
    tsp_pkg::t_rad r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad.valid <= 1'b0;
        end else begin
            r_rad.valid <= r_vd;
        end
        r_rad.cross_sq <= tsp_pkg::WRAD_BITS'(r_csq[0]) + tsp_pkg::WRAD_BITS'(r_csq[1])
                        + tsp_pkg::WRAD_BITS'(r_csq[2]);
        r_rad.len1_sq  <= r_q1d;
        r_rad.len2_sq  <= r_q2d;
        r_rad.side     <= r_side_d;
    end

    assign o_rad = r_rad;

endmodule
`default_nettype wire

@@ design/tsp_sqrt.sv @@
// Pipelined floor square roots, one result bit per stage, for the area radicand
// and both edge radicands side by side. Uses tsp_pkg types and constants.
`default_nettype none
module tsp_sqrt (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  tsp_pkg::t_rad                      i_rad,
    output logic                               o_valid,
    output logic [tsp_pkg::WROOT_BITS-1:0]     o_wroot,
    output logic [tsp_pkg::NROOT_BITS-1:0]     o_nroot1,
    output logic [tsp_pkg::NROOT_BITS-1:0]     o_nroot2,
    output tsp_pkg::t_side                     o_side
);

    localparam int WB = tsp_pkg::WRAD_BITS;
    localparam int NB = tsp_pkg::NRAD_BITS + 1;
    localparam int NS = tsp_pkg::WROOT_BITS;

    // Per stage: registered remainder and partial root of each radicand.
    logic           r_v    [NS];
    logic [WB-1:0]  r_wop  [NS];
    logic [WB-1:0]  r_wres [NS];
    logic [NB-1:0]  r_aop  [NS];
    logic [NB-1:0]  r_ares [NS];
    logic [NB-1:0]  r_bop  [NS];
    logic [NB-1:0]  r_bres [NS];
    tsp_pkg::t_side r_side [NS];

    // Inputs of each stage: the front end beat for the first, else the stage before.
    logic           w_v    [NS];
    logic [WB-1:0]  w_wop  [NS];
    logic [WB-1:0]  w_wres [NS];
    logic [NB-1:0]  w_aop  [NS];
    logic [NB-1:0]  w_ares [NS];
    logic [NB-1:0]  w_bop  [NS];
    logic [NB-1:0]  w_bres [NS];
    tsp_pkg::t_side w_side [NS];

    // Trial terms and compare outcomes of each stage.
    logic [WB-1:0]  w_wone [NS];
    logic [NB-1:0]  w_none [NS];
    logic [WB:0]    w_wt   [NS];
    logic           w_wge  [NS];
    logic [NB:0]    w_at   [NS];
    logic           w_age  [NS];
    logic [NB:0]    w_bt   [NS];
    logic           w_bge  [NS];

    always_comb begin
        w_v[0]    = i_rad.valid;
        w_wop[0]  = i_rad.cross_sq;
        w_wres[0] = '0;
        w_aop[0]  = NB'(i_rad.len1_sq);
        w_ares[0] = '0;
        w_bop[0]  = NB'(i_rad.len2_sq);
        w_bres[0] = '0;
        w_side[0] = i_rad.side;
        for (int k = 1; k < NS; k++) begin
            w_v[k]    = r_v[k-1];
            w_wop[k]  = r_wop[k-1];
            w_wres[k] = r_wres[k-1];
            w_aop[k]  = r_aop[k-1];
            w_ares[k] = r_ares[k-1];
            w_bop[k]  = r_bop[k-1];
            w_bres[k] = r_bres[k-1];
            w_side[k] = r_side[k-1];
        end
    end

    // Restoring step: stage k settles root bit NS-1-k where the trial term fits.
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_wone[k] = WB'(1) << (2 * (NS - 1 - k));
            w_none[k] = NB'(1) << (2 * (NS - 1 - k));
            w_wt[k]   = {1'b0, w_wres[k]} + {1'b0, w_wone[k]};
            w_wge[k]  = {1'b0, w_wop[k]} >= w_wt[k];
            w_at[k]   = {1'b0, w_ares[k]} + {1'b0, w_none[k]};
            w_age[k]  = {1'b0, w_aop[k]} >= w_at[k];
            w_bt[k]   = {1'b0, w_bres[k]} + {1'b0, w_none[k]};
            w_bge[k]  = {1'b0, w_bop[k]} >= w_bt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= w_v[k];
            end
            r_side[k] <= w_side[k];
            if (w_wge[k]) begin
                r_wop[k]  <= w_wop[k] - w_wt[k][WB-1:0];
                r_wres[k] <= (w_wres[k] >> 1) + w_wone[k];
            end else begin
                r_wop[k]  <= w_wop[k];
                r_wres[k] <= w_wres[k] >> 1;
            end
            // Edge roots only take part in their low result bits.
            if (NS - 1 - k >= tsp_pkg::NROOT_BITS) begin
                r_aop[k]  <= w_aop[k];
                r_ares[k] <= w_ares[k];
                r_bop[k]  <= w_bop[k];
                r_bres[k] <= w_bres[k];
            end else begin
                r_aop[k]  <= w_age[k] ? w_aop[k] - w_at[k][NB-1:0] : w_aop[k];
                r_ares[k] <= w_age[k] ? (w_ares[k] >> 1) + w_none[k]
                                      : w_ares[k] >> 1;
                r_bop[k]  <= w_bge[k] ? w_bop[k] - w_bt[k][NB-1:0] : w_bop[k];
                r_bres[k] <= w_bge[k] ? (w_bres[k] >> 1) + w_none[k]
                                      : w_bres[k] >> 1;
            end
        end
    end

    assign o_valid  = r_v[NS-1];
    assign o_wroot  = r_wres[NS-1][tsp_pkg::WROOT_BITS-1:0];
    assign o_nroot1 = r_ares[NS-1][tsp_pkg::NROOT_BITS-1:0];
    assign o_nroot2 = r_bres[NS-1][tsp_pkg::NROOT_BITS-1:0];
    assign o_side   = r_side[NS-1];

endmodule
`default_nettype wire

@@ design/triangle_surface_properties.sv @@
// Triangle surface properties: centroid, normal, area and edge lengths.
// The path from start to strobe runs through five arithmetic stages, 34 root
// stages (one area root bit each) and an output register. One triangle per cycle.
// busy stays low; the receiver cannot stall and every result shows for one cycle.
// Synchronous active-low reset clears all valid bits; no memory to clear.
`default_nettype none
module triangle_surface_properties (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             start,
    output logic            busy,
    input  tsp_pkg::t_in    i_item,
    output logic            o_strobe,
    output tsp_pkg::t_out   o_result
);

    tsp_pkg::t_rad                    w_rad;
    logic                             w_sv;
    logic [tsp_pkg::WROOT_BITS-1:0]   w_wroot;
    logic [tsp_pkg::NROOT_BITS-1:0]   w_len1, w_len2;
    tsp_pkg::t_side                   w_side;

    // The pipeline never backs up.
    assign busy = 1'b0;

    tsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_item  (i_item),
        .o_rad   (w_rad)
    );

    tsp_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rad    (w_rad),
        .o_valid  (w_sv),
        .o_wroot  (w_wroot),
        .o_nroot1 (w_len1),
        .o_nroot2 (w_len2),
        .o_side   (w_side)
    );

    // Output register: halve the area root and order the edge lengths.
    logic          r_strobe;
    tsp_pkg::t_out r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_sv;
        end
        r_result.center_x     <= w_side.center_x;
        r_result.center_y     <= w_side.center_y;
        r_result.center_z     <= w_side.center_z;
        r_result.normal_out_x <= w_side.normal_x;
        r_result.normal_out_y <= w_side.normal_y;
        r_result.normal_out_z <= w_side.normal_z;
        r_result.tri_area     <= w_wroot[tsp_pkg::WROOT_BITS-1:1];
        r_result.edge_long    <= (w_len1 > w_len2) ? w_len1 : w_len2;
        r_result.edge_short   <= (w_len1 > w_len2) ? w_len2 : w_len1;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A result beat only follows a matching start, checked against tsp_pkg::LATENCY.
    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, tsp_pkg::LATENCY))
        else $error("result beat without a matching start");

    // The ordered edge lengths never cross.
    a_edge_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.edge_long >= o_result.edge_short))
        else $error("edge lengths out of order");

    // A triangle whose edges are both zero has zero area.
    a_zero_tri: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.edge_long == 17'd0) |-> (o_result.tri_area == 33'd0))
        else $error("area of a point triangle is not zero");

endmodule
`default_nettype wire
